@@ hdl/esc_pkg.sv @@
// Shared types and constants for the seconds-to-calendar converter.
package esc_pkg;

  // Configuration map
  localparam int unsigned CFG_AW     = 3;
  localparam int unsigned CFG_DW     = 32;
  localparam logic        REG_EPOCH_OFFSET = 1'b0;   // word index, paddr[2]
  localparam logic [31:0] EPOCH_OFFSET_RST = 32'd946684800;

  // Stream widths
  localparam int unsigned IN_DW  = 32;
  localparam int unsigned OUT_DW = 56;

  // Pipeline depth
  localparam int unsigned NUM_STAGES = 9;

  // Reciprocal constants for the constant divides
  localparam logic [31:0] RECIP_60   = 32'h8888_8889;  // x/60 = (x*R) >> 37, 32-bit x
  localparam int unsigned SHIFT_60   = 37;
  localparam logic [17:0] RECIP_3    = 18'd174763;     // x/3 = (x*R) >> 19, 18-bit x
  localparam logic [15:0] RECIP_1461 = 16'd45934;      // x/1461 = (x*R) >> 26, 16-bit x
  localparam logic [17:0] RECIP_7    = 18'd149797;     // x/7 = (x*R) >> 20, 17-bit x

  localparam logic [15:0] DAYS_PER_QUAD = 16'd1461;
  localparam logic [16:0] WEEKDAY_BIAS  = 17'd6;

  // First day of each month, zero based, common year
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Work item as it travels down the pipe
  typedef struct packed {
    logic [31:0] t;
    logic [26:0] q_min;     // total minutes
    logic [20:0] q_hour;    // total hours
    logic [15:0] days;
    logic [5:0]  quad;      // four-year blocks
    logic [12:0] weeks;
    logic [10:0] rem;       // day within the four-year block
    logic [8:0]  doy;
    logic        leap;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } item_t;

endpackage

@@ hdl/epoch_seconds_to_calendar_unit.sv @@
// Seconds timestamp to calendar date and time converter, 2000 epoch.
//
//  channel  | dir | payload                                   | transfer when
//  ---------+-----+-------------------------------------------+-------------------------
//  in_      | in  | timestamp_seconds (32)                    | in_tvalid & in_tready
//  out_     | out | year..day_count (53, zero padded to 56)   | out_tvalid & out_tready
//  cfg_     | in  | epoch_offset at byte address 0 (APB)      | psel & penable & pwrite
//
// Nine register stages, each timestamp passing through all of them in order.
// One transfer per cycle sustained while out_tready stays high; the depth is set
// by the reciprocal multipliers (60 twice, 3, 1461, 7), each in a registered stage.
// Each stage loads whenever it is empty or the stage after it moves, so a
// stalled output holds its result while bubbles further up still close.
// rst_n (synchronous) empties the pipe and reloads epoch_offset.
module epoch_seconds_to_calendar_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [esc_pkg::IN_DW-1:0]   in_tdata,   // [31:0] timestamp_seconds
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] year_offset, [11:8] month_number, [16:12] day_of_month,
  // [21:17] hour_of_day, [27:22] minute_of_hour, [33:28] second_of_minute,
  // [36:34] weekday, [52:37] day_count, [55:53] zero
  output logic [esc_pkg::OUT_DW-1:0]  out_tdata,
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [esc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [esc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [esc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int unsigned NS = esc_pkg::NUM_STAGES;

  logic [31:0]          epoch_offset_r;
  logic [NS-1:0]        vld_r;
  logic [NS-1:0]        vld_in;
  logic [NS-1:0]        rdy;
  esc_pkg::item_t       st_r   [NS];
  esc_pkg::item_t       st_nxt [NS];
  logic                 cfg_wr;

  // ------------------------------------------------------------------
  // Configuration port: single register, zero-wait APB
  // ------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_offset_r <= esc_pkg::EPOCH_OFFSET_RST;
    end else if (cfg_wr && cfg_paddr[2] == esc_pkg::REG_EPOCH_OFFSET) begin
      epoch_offset_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == esc_pkg::REG_EPOCH_OFFSET) ? epoch_offset_r : '0;

  // ------------------------------------------------------------------
  // Flow control: a stage loads when empty or when its successor moves
  // ------------------------------------------------------------------
  assign vld_in = {vld_r[NS-2:0], in_tvalid};

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  // ------------------------------------------------------------------
  // Datapath, one block of work per stage
  // ------------------------------------------------------------------
  always_comb begin
    logic [63:0] p_min;
    logic [63:0] p_hour;
    logic [35:0] p_day;
    logic [31:0] p_quad;
    logic [34:0] p_week;
    logic [16:0] wk_in;
    logic [15:0] quad_days;
    logic [10:0] r;
    logic [3:0]  mcnt;
    logic [8:0]  thr;
    logic [3:0]  midx;
    logic [8:0]  mstart;

    // stage 0: rebase onto 2000-01-01, wraps modulo 2^32
    st_nxt[0]   = '0;
    st_nxt[0].t = in_tdata - epoch_offset_r;

    // stage 1: total minutes
    st_nxt[1]       = st_r[0];
    p_min           = 64'(st_r[0].t) * 64'(esc_pkg::RECIP_60);
    st_nxt[1].q_min = p_min[esc_pkg::SHIFT_60 +: 27];

    // stage 2: seconds, total hours
    st_nxt[2]        = st_r[1];
    st_nxt[2].second = 6'(st_r[1].t[5:0] - 6'(st_r[1].q_min[5:0] * 6'd60));
    p_hour           = 64'(st_r[1].q_min) * 64'(esc_pkg::RECIP_60);
    st_nxt[2].q_hour = p_hour[esc_pkg::SHIFT_60 +: 21];

    // stage 3: minutes, days = (hours / 8) / 3
    st_nxt[3]        = st_r[2];
    st_nxt[3].minute = 6'(st_r[2].q_min[5:0] - 6'(st_r[2].q_hour[5:0] * 6'd60));
    p_day            = 36'(st_r[2].q_hour[20:3]) * 36'(esc_pkg::RECIP_3);
    st_nxt[3].days   = p_day[34:19];

    // stage 4: hours, four-year blocks, weeks
    st_nxt[4]       = st_r[3];
    st_nxt[4].hour  = 5'(st_r[3].q_hour[4:0] - 5'(st_r[3].days[4:0] * 5'd24));
    p_quad          = 32'(st_r[3].days) * 32'(esc_pkg::RECIP_1461);
    st_nxt[4].quad  = p_quad[31:26];
    wk_in           = 17'(st_r[3].days) + esc_pkg::WEEKDAY_BIAS;
    p_week          = 35'(wk_in) * 35'(esc_pkg::RECIP_7);
    st_nxt[4].weeks = p_week[32:20];

    // stage 5: day within block, weekday
    st_nxt[5]         = st_r[4];
    quad_days         = 16'(st_r[4].quad) * esc_pkg::DAYS_PER_QUAD;
    st_nxt[5].rem     = 11'(st_r[4].days - quad_days);
    wk_in             = 17'(st_r[4].days) + esc_pkg::WEEKDAY_BIAS;
    st_nxt[5].weekday = 3'(wk_in[2:0] - 3'(st_r[4].weeks[2:0] * 3'd7));

    // stage 6: year within block; the first year of each block is leap
    st_nxt[6] = st_r[5];
    r         = st_r[5].rem;
    if (r < 11'd366) begin
      st_nxt[6].year = {st_r[5].quad, 2'd0};
      st_nxt[6].doy  = 9'(r);
      st_nxt[6].leap = 1'b1;
    end else if (r < 11'd731) begin
      st_nxt[6].year = {st_r[5].quad, 2'd1};
      st_nxt[6].doy  = 9'(r - 11'd366);
      st_nxt[6].leap = 1'b0;
    end else if (r < 11'd1096) begin
      st_nxt[6].year = {st_r[5].quad, 2'd2};
      st_nxt[6].doy  = 9'(r - 11'd731);
      st_nxt[6].leap = 1'b0;
    end else begin
      st_nxt[6].year = {st_r[5].quad, 2'd3};
      st_nxt[6].doy  = 9'(r - 11'd1096);
      st_nxt[6].leap = 1'b0;
    end

    // stage 7: month by comparing against every month start after January
    st_nxt[7] = st_r[6];
    mcnt      = 4'd1;
    for (int k = 1; k < 12; k++) begin
      thr = esc_pkg::MONTH_START[k] + 9'((st_r[6].leap && k >= 2) ? 1 : 0);
      if (st_r[6].doy >= thr) begin
        mcnt = mcnt + 4'd1;
      end
    end
    st_nxt[7].month = mcnt;

    // stage 8: day of month
    st_nxt[8]     = st_r[7];
    midx          = st_r[7].month - 4'd1;
    mstart        = esc_pkg::MONTH_START[midx] +
                    9'((st_r[7].leap && st_r[7].month >= 4'd3) ? 1 : 0);
    st_nxt[8].day = 5'(st_r[7].doy - mstart + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k] && vld_in[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // ------------------------------------------------------------------
  // Result
  // ------------------------------------------------------------------
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = {3'b000,
                       st_r[NS-1].days,
                       st_r[NS-1].weekday,
                       st_r[NS-1].second,
                       st_r[NS-1].minute,
                       st_r[NS-1].hour,
                       st_r[NS-1].day,
                       st_r[NS-1].month,
                       st_r[NS-1].year};

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st_r[NS-1].month >= 4'd1 && st_r[NS-1].month <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st_r[NS-1].day >= 5'd1 && st_r[NS-1].weekday <= 3'd6 &&
                    st_r[NS-1].hour <= 5'd23 && st_r[NS-1].minute <= 6'd59 &&
                    st_r[NS-1].second <= 6'd59))
    else $error("calendar field out of range");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r))
    else $error("input blocked with a bubble in the pipe");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NS-2] && !rdy[NS-2]) |=> (vld_r[NS-2] && $stable(st_r[NS-2])))
    else $error("stalled stage lost or changed its item");

endmodule

@@ dv/epoch_seconds_to_calendar_unit_tb.sv @@
// Self-checking testbench for the seconds-to-calendar converter: stream stimulus, APB set-up.
module epoch_seconds_to_calendar_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Result word as laid out on out_tdata, lowest field last
  typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] day_count;
    logic [2:0]  weekday;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [7:0]  year;
  } calendar_t;

  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned LAST_DAY       = 49710;   // day count of 2^32-1 seconds
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Register map: index 0 is the offset, index 1 decodes to nothing
  localparam logic [esc_pkg::CFG_AW-1:0] ADDR_EPOCH_OFFSET = {esc_pkg::REG_EPOCH_OFFSET, 2'b00};
  localparam logic [esc_pkg::CFG_AW-1:0] ADDR_UNMAPPED     = {~esc_pkg::REG_EPOCH_OFFSET, 2'b00};

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [esc_pkg::IN_DW-1:0]   in_tdata;     // [31:0] timestamp_seconds
  logic                        out_tvalid;
  logic                        out_tready;
  // [7:0] year_offset, [11:8] month_number, [16:12] day_of_month, [21:17] hour_of_day,
  // [27:22] minute_of_hour, [33:28] second_of_minute, [36:34] weekday, [52:37] day_count
  logic [esc_pkg::OUT_DW-1:0]  out_tdata;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [esc_pkg::CFG_AW-1:0]  cfg_paddr;
  logic [esc_pkg::CFG_DW-1:0]  cfg_pwdata;
  logic [esc_pkg::CFG_DW-1:0]  cfg_prdata;
  logic                        cfg_pready;

  // Shadow of the offset register, updated as each write lands
  logic [31:0]  offset_shadow;
  calendar_t    pending_dates [$];
  int unsigned  fail_count;
  int unsigned  idle_cycles;
  int unsigned  stall_left;
  bit           tx_steady;
  bit           rx_steady;

  epoch_seconds_to_calendar_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Calendar predictor. Split the offset-corrected count into h:m:s and days,
  // then peel whole years off (every fourth year from 2000 is leap, 2100 too)
  // and whole months, the last month absorbing whatever is left.
  // ---------------------------------------------------------------------------
  function automatic calendar_t to_calendar(logic [31:0] stamp, logic [31:0] offset);
    logic [31:0] t;
    int unsigned days;
    int unsigned rem;
    int unsigned yr;
    int unsigned mon;
    int unsigned len;
    bit          leap;
    calendar_t   c;
    c = '0;
    t = stamp - offset;            // wraps below the offset, no saturation
    c.second = 6'(t % 60);
    t        = t / 60;
    c.minute = 6'(t % 60);
    t        = t / 60;
    c.hour   = 5'(t % 24);
    days     = t / 24;

    rem  = days;
    yr   = 0;
    leap = 1'b1;
    while (rem >= 365 + leap) begin
      rem  = rem - (365 + leap);
      yr   = yr + 1;
      leap = (yr % 4 == 0);
    end

    mon = 1;
    len = MONTH_DAYS[0];
    while (rem >= len && mon < 12) begin
      rem = rem - len;
      mon = mon + 1;
      len = MONTH_DAYS[mon-1] + ((leap && mon == 2) ? 1 : 0);
    end

    c.year      = 8'(yr);
    c.month     = 4'(mon);
    c.day       = 5'(rem + 1);
    c.weekday   = 3'((days + 6) % 7);  // 2000-01-01 was a Saturday
    c.day_count = 16'(days);
    return c;
  endfunction

  // Input timestamp that lands on a given day and time under the current offset
  function automatic logic [31:0] stamp_of(int unsigned days, int unsigned h,
                                           int unsigned m, int unsigned s);
    logic [31:0] secs;
    secs = days * SECS_PER_DAY + h * 3600 + m * 60 + s;
    return secs + offset_shadow;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned gap_len(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90)           return $urandom_range(1, 3);
    if (r < 97)           return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus primitives. All are entered just after a rising edge; handshakes
  // are sampled at the falling edge, when every signal has settled.
  // ---------------------------------------------------------------------------
  task automatic send_stamp(logic [31:0] stamp);
    int unsigned n;
    in_tvalid <= 1'b1;
    in_tdata  <= stamp;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);                        // transfer happens on this edge
    pending_dates.push_back(to_calendar(stamp, offset_shadow));
    n = gap_len(tx_steady);
    if (n != 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic cfg_write(logic [esc_pkg::CFG_AW-1:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    @(posedge clk);                        // register loads here
    if (addr == ADDR_EPOCH_OFFSET) offset_shadow = data;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Read the offset back and compare with the shadow copy
  task automatic cfg_check_offset();
    logic [31:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_EPOCH_OFFSET;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    check_field("epoch_offset", offset_shadow, got);
  endtask

  // Let the pipe empty before touching the register or ending
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (esc_pkg::NUM_STAGES + 2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset value of the offset, the epoch itself and both wrap directions
  task automatic test_reset_offset();
    cfg_check_offset();
    send_stamp(esc_pkg::EPOCH_OFFSET_RST);          // Saturday 2000-01-01 00:00:00
    send_stamp(esc_pkg::EPOCH_OFFSET_RST + 1);
    send_stamp(esc_pkg::EPOCH_OFFSET_RST - 1);      // wraps to the very last second
    send_stamp(32'h0000_0000);                      // below the offset, wrapped
    send_stamp(32'hFFFF_FFFF);
    drain();
  endtask

  // Leap days, year ends, the 2100 leap year and the top of the range
  task automatic test_calendar_edges();
    int unsigned first;
    cfg_write(ADDR_EPOCH_OFFSET, 32'h0000_0000);
    cfg_check_offset();
    send_stamp(stamp_of(0, 23, 59, 59));
    send_stamp(stamp_of(59, 12, 0, 0));    // 29 Feb 2000
    send_stamp(stamp_of(60, 0, 0, 0));     // 1 Mar 2000
    send_stamp(stamp_of(365, 23, 59, 59)); // 31 Dec 2000
    send_stamp(stamp_of(424, 23, 59, 59)); // 28 Feb 2001
    send_stamp(stamp_of(1460, 23, 59, 59));
    send_stamp(stamp_of(1461, 0, 0, 0));   // 1 Jan 2004
    send_stamp(stamp_of(36584, 6, 30, 1)); // 29 Feb 2100, still leap here
    send_stamp(stamp_of(36585, 0, 0, 0));
    send_stamp(32'hFFFF_FFFF);
    // first day of every month of a common year
    first = 366;
    for (int m = 0; m < 12; m++) begin
      send_stamp(stamp_of(first, $urandom_range(0, 23), $urandom_range(0, 59),
                          $urandom_range(0, 59)));
      first += MONTH_DAYS[m];
    end
    drain();
  endtask

  // A write to an address with no register must leave the offset alone
  task automatic test_unmapped_write();
    cfg_write(ADDR_UNMAPPED, $urandom());
    cfg_check_offset();
    for (int i = 0; i < 4; i++) send_stamp($urandom());
    drain();
  endtask

  // Random timestamps under one offset: half uniform, the rest at the end or start
  // of a random day or just around the offset itself
  task automatic test_random_stream(logic [31:0] offset, int unsigned count, bit steady);
    int unsigned kind;
    cfg_write(ADDR_EPOCH_OFFSET, offset);
    cfg_check_offset();
    tx_steady = steady;
    rx_steady <= steady;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5)
        send_stamp($urandom());
      else if (kind < 7)
        send_stamp(stamp_of($urandom_range(0, LAST_DAY), 23, 59, 59));
      else if (kind < 9)
        send_stamp(stamp_of($urandom_range(0, LAST_DAY), 0, 0, $urandom_range(0, 1)));
      else
        send_stamp(offset_shadow + $urandom_range(0, 200) - 100);
    end
    drain();
    tx_steady = 1'b0;
    rx_steady <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure with occasional long stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_steady || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
                                                  : $urandom_range(0, 3);
    end
  end

  // Each result transfer is checked against the oldest outstanding prediction
  always @(negedge clk) begin
    calendar_t want;
    calendar_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_dates.size() == 0) begin
        $error("result %h with no timestamp outstanding", out_tdata);
        fail_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year_offset",      32'(want.year),      32'(got.year));
        check_field("month_number",     32'(want.month),     32'(got.month));
        check_field("day_of_month",     32'(want.day),       32'(got.day));
        check_field("hour_of_day",      32'(want.hour),      32'(got.hour));
        check_field("minute_of_hour",   32'(want.minute),    32'(got.minute));
        check_field("second_of_minute", 32'(want.second),    32'(got.second));
        check_field("weekday",          32'(want.weekday),   32'(got.weekday));
        check_field("day_count",        32'(want.day_count), 32'(got.day_count));
        check_field("padding",          32'(want.pad),       32'(got.pad));
      end
    end
  end

  // Watchdog: any transfer or register access counts as progress
  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    offset_shadow = esc_pkg::EPOCH_OFFSET_RST;
    fail_count    = 0;
    idle_cycles   = 0;
    stall_left    = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_offset();
    test_calendar_edges();
    test_unmapped_write();
    test_random_stream(esc_pkg::EPOCH_OFFSET_RST, 500, 1'b0);
    test_random_stream(32'h0000_0000, 400, 1'b0);
    test_random_stream(32'hFFFF_FFFF, 300, 1'b0);
    test_random_stream($urandom(), 300, 1'b1);
    test_random_stream($urandom(), 400, 1'b0);

    if (fail_count == 0 && pending_dates.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ epoch_seconds_to_calendar_unit.f @@
hdl/esc_pkg.sv
hdl/epoch_seconds_to_calendar_unit.sv
dv/epoch_seconds_to_calendar_unit_tb.sv
